// ----- rtl/core/agcl_pkg.sv -----
// Shared types and constants of the AGC leveler.
// Used by agcl_mul, agcl_div and audio_agc_leveler; depends on nothing.
package agcl_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 17;
  localparam int ENV_W      = 24;
  localparam int GAIN_W     = 23;
  localparam int COEF_W     = 24;
  localparam int TARGET_W   = 15;
  localparam int VOL_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 39;
  localparam int DIV_N_W = 39;
  localparam int DIV_D_W = 25;
  localparam int CNT_W   = 6;
  localparam int RND_W   = 28;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 23'd65536;
  localparam logic [GAIN_W-1:0] GAIN_MIN = 23'd16384;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 23'd6553600;
  localparam logic [15:0]       SMOOTH_K = 16'd33554;

  localparam logic [CNT_W-1:0] ENV_STEPS    = 6'd24;
  localparam logic [CNT_W-1:0] DIV_STEPS    = 6'd39;
  localparam logic [CNT_W-1:0] SMOOTH_STEPS = 6'd16;
  localparam logic [CNT_W-1:0] GVOL_STEPS   = 6'd23;
  localparam logic [CNT_W-1:0] MAGT_STEPS   = 6'd39;

  localparam logic [CFG_IDX_W-1:0] REG_AGC_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME       = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENV,
    S_DIV,
    S_SMOOTH,
    S_GVOL,
    S_MAGT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } unit_ctl_t;

endpackage

// ----- rtl/core/agcl_mul.sv -----
// Bit-serial shift-add multiplier, one bit per step cycle, LSB first.
// Product of n steps sits in {hi, lo} shifted right by MUL_B_W - n.
// Depends on agcl_pkg.
module agcl_mul (
  input  logic                         clk,
  input  agcl_pkg::unit_ctl_t          ctl,
  input  logic [agcl_pkg::MUL_A_W-1:0] a_in,
  input  logic [agcl_pkg::MUL_B_W-1:0] b_in,
  output logic [agcl_pkg::MUL_A_W-1:0] hi,
  output logic [agcl_pkg::MUL_B_W-1:0] lo
);

  logic [agcl_pkg::MUL_A_W-1:0] a;
  logic [agcl_pkg::MUL_A_W:0]   sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a} : '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a  <= a_in;
      hi <= '0;
      lo <= b_in;
    end else if (ctl.step) begin
      hi <= sum[agcl_pkg::MUL_A_W:1];
      lo <= {sum[0], lo[agcl_pkg::MUL_B_W-1:1]};
    end
  end

endmodule

// ----- rtl/core/agcl_div.sv -----
// Restoring radix-2 divider: (num << 24) / den, a quotient bit per step cycle.
// Depends on agcl_pkg.
module agcl_div (
  input  logic                          clk,
  input  agcl_pkg::unit_ctl_t           ctl,
  input  logic [agcl_pkg::TARGET_W-1:0] num_in,
  input  logic [agcl_pkg::DIV_D_W-1:0]  den_in,
  output logic [agcl_pkg::DIV_N_W-1:0]  quo
);

  logic [agcl_pkg::DIV_N_W-1:0] dnd;
  logic [agcl_pkg::DIV_D_W-1:0] den;
  logic [agcl_pkg::DIV_D_W-1:0] rem;
  logic [agcl_pkg::DIV_D_W:0]   rem2;
  logic [agcl_pkg::DIV_D_W:0]   trial;

  assign rem2  = {rem, dnd[agcl_pkg::DIV_N_W-1]};
  assign trial = rem2 - {1'b0, den};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dnd <= {num_in, {(agcl_pkg::DIV_N_W - agcl_pkg::TARGET_W){1'b0}}};
      den <= den_in;
      rem <= '0;
      quo <= '0;
    end else if (ctl.step) begin
      dnd <= {dnd[agcl_pkg::DIV_N_W-2:0], 1'b0};
      if (!trial[agcl_pkg::DIV_D_W]) begin
        rem <= trial[agcl_pkg::DIV_D_W-1:0];
        quo <= {quo[agcl_pkg::DIV_N_W-2:0], 1'b1};
      end else begin
        rem <= rem2[agcl_pkg::DIV_D_W-1:0];
        quo <= {quo[agcl_pkg::DIV_N_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/core/audio_agc_leveler.sv -----
// Audio AGC leveler top level: sequencer, state, config registers, output register.
// Depends on agcl_pkg, agcl_mul and agcl_div.
//
// Usage: one signed Q1.15 sample enters on in_valid/in_stall and one leveled
// sample leaves on out_valid/out_stall per word. Config registers are written
// through cfg_wr_en/cfg_index/cfg_data; the user must write them only while
// no word is in flight, and the block itself does not enforce this.
// With AGC on and volume nonzero a word runs the envelope step, the divide,
// gain smoothing, gain times volume and sample times gain in turn; with AGC
// off it runs gain times volume and sample times gain only; with volume zero
// it goes straight to done with a zero result. The multiplies run on the
// bit-serial multiplier and the divide on the radix-2 divider.
// in_stall stays high from accept until the result moves to the output
// register. The output register holds a word while out_stall is high; the
// finished result waits in the core meanwhile and no new word is taken.
// Reset (synchronous, rst high) restores register defaults, clears the
// envelope, sets the applied gain to 1.0 and empties the output register.
module audio_agc_leveler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [agcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [agcl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [agcl_pkg::SAMPLE_W-1:0] sample_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [agcl_pkg::SAMPLE_W-1:0] sample_out
);

  logic                            agc_enable;
  logic [agcl_pkg::TARGET_W-1:0]   target_level;
  logic [agcl_pkg::COEF_W-1:0]     attack_coef;
  logic [agcl_pkg::COEF_W-1:0]     release_coef;
  logic [agcl_pkg::VOL_W-1:0]      volume;

  agcl_pkg::state_t                state, state_next;
  logic [agcl_pkg::CNT_W-1:0]      cnt, cnt_next;
  logic [agcl_pkg::MAG_W-1:0]      mag;
  logic                            neg;
  logic                            dir_up;
  logic [agcl_pkg::ENV_W-1:0]      env;
  logic [agcl_pkg::GAIN_W-1:0]     gain;
  logic [agcl_pkg::SAMPLE_W-1:0]   res;

  agcl_pkg::unit_ctl_t             mul_ctl, div_ctl;
  logic [agcl_pkg::MUL_A_W-1:0]    mul_a, mul_hi;
  logic [agcl_pkg::MUL_B_W-1:0]    mul_b, mul_lo;
  logic [agcl_pkg::DIV_N_W-1:0]    quo;

  logic                            in_fire;
  logic                            run_done;
  logic                            out_free;
  logic [agcl_pkg::MAG_W-1:0]      in_mag;
  logic [agcl_pkg::ENV_W-1:0]      in_m;
  logic                            env_up_in;
  logic [agcl_pkg::ENV_W-1:0]      env_gap;
  logic [agcl_pkg::ENV_W-1:0]      env_upd;
  logic [agcl_pkg::DIV_D_W-1:0]    div_den;
  logic [agcl_pkg::GAIN_W-1:0]     g_clamp;
  logic                            g_up;
  logic [agcl_pkg::GAIN_W-1:0]     g_gap;
  logic [15:0]                     g_step;
  logic [agcl_pkg::GAIN_W-1:0]     gain_upd;
  logic [agcl_pkg::MUL_B_W-1:0]    gvol;
  logic [agcl_pkg::RND_W-1:0]      rnd;
  logic [agcl_pkg::SAMPLE_W-1:0]   r_sat;
  logic [agcl_pkg::SAMPLE_W-1:0]   res_val;

  agcl_mul u_mul (
    .clk  (clk),
    .ctl  (mul_ctl),
    .a_in (mul_a),
    .b_in (mul_b),
    .hi   (mul_hi),
    .lo   (mul_lo)
  );

  agcl_div u_div (
    .clk    (clk),
    .ctl    (div_ctl),
    .num_in (target_level),
    .den_in (div_den),
    .quo    (quo)
  );

  assign in_stall = rst || (state != agcl_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign run_done = (cnt == '0);
  assign out_free = !out_valid || !out_stall;

  assign in_mag    = sample_in[agcl_pkg::SAMPLE_W-1]
                     ? agcl_pkg::MAG_W'(-{sample_in[agcl_pkg::SAMPLE_W-1], sample_in})
                     : {1'b0, sample_in};
  assign in_m      = {in_mag[agcl_pkg::SAMPLE_W-1:0], 8'd0};
  assign env_up_in = in_m > env;
  assign env_gap   = env_up_in ? (in_m - env) : (env - in_m);

  assign env_upd = dir_up ? (env + mul_hi) : (env - mul_hi);
  assign div_den = {1'b0, env_upd} + agcl_pkg::DIV_D_W'(1);

  always_comb begin
    if (quo > agcl_pkg::DIV_N_W'(agcl_pkg::GAIN_MAX)) begin
      g_clamp = agcl_pkg::GAIN_MAX;
    end else if (quo < agcl_pkg::DIV_N_W'(agcl_pkg::GAIN_MIN)) begin
      g_clamp = agcl_pkg::GAIN_MIN;
    end else begin
      g_clamp = quo[agcl_pkg::GAIN_W-1:0];
    end
  end

  assign g_up     = g_clamp >= gain;
  assign g_gap    = g_up ? (g_clamp - gain) : (gain - g_clamp);
  assign g_step   = mul_hi[23:8] + 16'(mul_hi[7]);
  assign gain_upd = dir_up ? (gain + agcl_pkg::GAIN_W'(g_step))
                           : (gain - agcl_pkg::GAIN_W'(g_step));

  assign gvol = {mul_hi[15:0], mul_lo[agcl_pkg::MUL_B_W-1:16]};
  assign rnd  = {mul_hi[16:0], mul_lo[agcl_pkg::MUL_B_W-1:28]}
                + agcl_pkg::RND_W'(mul_lo[27]);

  always_comb begin
    if (neg) begin
      r_sat   = (rnd > agcl_pkg::RND_W'(32768)) ? 16'd32768 : rnd[15:0];
      res_val = 16'(-r_sat);
    end else begin
      r_sat   = (rnd > agcl_pkg::RND_W'(32767)) ? 16'd32767 : rnd[15:0];
      res_val = r_sat;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      agcl_pkg::S_IDLE: begin
        if (in_fire) begin
          if (volume == '0) begin
            state_next = agcl_pkg::S_DONE;
          end else if (agc_enable) begin
            state_next = agcl_pkg::S_ENV;
          end else begin
            state_next = agcl_pkg::S_GVOL;
          end
        end
      end
      agcl_pkg::S_ENV:    if (run_done) state_next = agcl_pkg::S_DIV;
      agcl_pkg::S_DIV:    if (run_done) state_next = agcl_pkg::S_SMOOTH;
      agcl_pkg::S_SMOOTH: if (run_done) state_next = agcl_pkg::S_GVOL;
      agcl_pkg::S_GVOL:   if (run_done) state_next = agcl_pkg::S_MAGT;
      agcl_pkg::S_MAGT:   if (run_done) state_next = agcl_pkg::S_DONE;
      agcl_pkg::S_DONE:   if (out_free) state_next = agcl_pkg::S_IDLE;
      default:            state_next = agcl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mul_ctl  = '0;
    div_ctl  = '0;
    mul_a    = '0;
    mul_b    = '0;
    cnt_next = run_done ? cnt : (cnt - agcl_pkg::CNT_W'(1));
    unique case (state)
      agcl_pkg::S_IDLE: begin
        if (in_fire && (volume != '0)) begin
          mul_ctl.load = 1'b1;
          if (agc_enable) begin
            mul_a    = env_up_in ? attack_coef : release_coef;
            mul_b    = agcl_pkg::MUL_B_W'(env_gap);
            cnt_next = agcl_pkg::ENV_STEPS;
          end else begin
            mul_a    = agcl_pkg::MUL_A_W'(volume);
            mul_b    = agcl_pkg::MUL_B_W'(agcl_pkg::GAIN_ONE);
            cnt_next = agcl_pkg::GVOL_STEPS;
          end
        end
      end
      agcl_pkg::S_ENV: begin
        mul_ctl.step = !run_done;
        if (run_done) begin
          div_ctl.load = 1'b1;
          cnt_next     = agcl_pkg::DIV_STEPS;
        end
      end
      agcl_pkg::S_DIV: begin
        div_ctl.step = !run_done;
        if (run_done) begin
          mul_ctl.load = 1'b1;
          mul_a        = agcl_pkg::MUL_A_W'(g_gap);
          mul_b        = agcl_pkg::MUL_B_W'(agcl_pkg::SMOOTH_K);
          cnt_next     = agcl_pkg::SMOOTH_STEPS;
        end
      end
      agcl_pkg::S_SMOOTH: begin
        mul_ctl.step = !run_done;
        if (run_done) begin
          mul_ctl.load = 1'b1;
          mul_a        = agcl_pkg::MUL_A_W'(volume);
          mul_b        = agcl_pkg::MUL_B_W'(gain_upd);
          cnt_next     = agcl_pkg::GVOL_STEPS;
        end
      end
      agcl_pkg::S_GVOL: begin
        mul_ctl.step = !run_done;
        if (run_done) begin
          mul_ctl.load = 1'b1;
          mul_a        = agcl_pkg::MUL_A_W'(mag);
          mul_b        = gvol;
          cnt_next     = agcl_pkg::MAGT_STEPS;
        end
      end
      agcl_pkg::S_MAGT: begin
        mul_ctl.step = !run_done;
      end
      agcl_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= agcl_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      agc_enable   <= 1'b1;
      target_level <= 15'd9830;
      attack_coef  <= 24'd34900;
      release_coef <= 24'd2330;
      volume       <= 16'd4096;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        agcl_pkg::REG_AGC_ENABLE:   agc_enable   <= cfg_data[0];
        agcl_pkg::REG_TARGET_LEVEL: target_level <= cfg_data[agcl_pkg::TARGET_W-1:0];
        agcl_pkg::REG_ATTACK_COEF:  attack_coef  <= cfg_data[agcl_pkg::COEF_W-1:0];
        agcl_pkg::REG_RELEASE_COEF: release_coef <= cfg_data[agcl_pkg::COEF_W-1:0];
        agcl_pkg::REG_VOLUME:       volume       <= cfg_data[agcl_pkg::VOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env  <= '0;
      gain <= agcl_pkg::GAIN_ONE;
    end else begin
      if ((state == agcl_pkg::S_ENV) && run_done) begin
        env <= env_upd;
      end
      if ((state == agcl_pkg::S_SMOOTH) && run_done) begin
        gain <= gain_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag    <= in_mag;
      neg    <= sample_in[agcl_pkg::SAMPLE_W-1];
      dir_up <= env_up_in;
    end else if ((state == agcl_pkg::S_DIV) && run_done) begin
      dir_up <= g_up;
    end
    if (in_fire && (volume == '0)) begin
      res <= '0;
    end else if ((state == agcl_pkg::S_MAGT) && run_done) begin
      res <= res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == agcl_pkg::S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == agcl_pkg::S_DONE) && out_free) begin
      sample_out <= res;
    end
  end

  a_mute_path: assert property (@(posedge clk) disable iff (rst)
    ((state == agcl_pkg::S_IDLE) && in_valid && (volume == '0))
    |=> ((state == agcl_pkg::S_DONE) && (res == '0)))
    else $error("muted word did not go straight to done with zero result");

  a_gain_hold: assert property (@(posedge clk) disable iff (rst)
    !((state == agcl_pkg::S_SMOOTH) && run_done) |=> (gain == $past(gain)))
    else $error("applied gain moved outside the smoothing step");

  a_env_hold: assert property (@(posedge clk) disable iff (rst)
    !((state == agcl_pkg::S_ENV) && run_done) |=> (env == $past(env)))
    else $error("envelope moved outside the envelope step");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == agcl_pkg::S_DONE))
    else $error("output word appeared without a finished result");

endmodule

// ----- dv/tb_audio_agc_leveler.sv -----
// Self-checking testbench for audio_agc_leveler: directed edge cases, then random
// register settings and sample streams, with idling on both sides of the word flow.
// Depends on agcl_pkg and the audio_agc_leveler RTL.
module tb_audio_agc_leveler;
  import agcl_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RAND_WORDS   = 2000;
  localparam int DRAIN_CYCLES = 160;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int MAX_REPORTS  = 20;

  class level_tracker;
    logic                 agc_on;
    logic [TARGET_W-1:0]  target;
    logic [COEF_W-1:0]    attack;
    logic [COEF_W-1:0]    release_k;
    logic [VOL_W-1:0]     vol;
    logic [ENV_W-1:0]     env_q;
    logic [GAIN_W-1:0]    gain_q;
    logic signed [SAMPLE_W-1:0] leveled_due[$];
    int errors;
    int checked;

    function new();
      agc_on    = 1'b1;
      target    = 15'd9830;
      attack    = 24'd34900;
      release_k = 24'd2330;
      vol       = 16'd4096;
      env_q     = '0;
      gain_q    = GAIN_ONE;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_AGC_ENABLE:   agc_on = data[0];
        REG_TARGET_LEVEL: target = data[TARGET_W-1:0];
        REG_ATTACK_COEF:  attack = data[COEF_W-1:0];
        REG_RELEASE_COEF: release_k = data[COEF_W-1:0];
        REG_VOLUME:       vol = data[VOL_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] s);
      logic [MAG_W-1:0]    mag;
      logic [ENV_W-1:0]    m;
      logic [63:0]         step;
      logic [63:0]         quo;
      logic [63:0]         prod;
      logic [63:0]         r;
      logic [GAIN_W-1:0]   want;
      logic [GAIN_W-1:0]   gain;
      mag = s[SAMPLE_W-1] ? MAG_W'(-int'(s)) : MAG_W'(s);
      if (vol == '0) begin
        leveled_due.push_back('0);
        return;
      end
      if (agc_on) begin
        m = ENV_W'({mag, 8'd0});
        if (m > env_q) begin
          step  = (64'(attack) * 64'(m - env_q)) >> 24;
          env_q = env_q + ENV_W'(step);
        end else begin
          step  = (64'(release_k) * 64'(env_q - m)) >> 24;
          env_q = env_q - ENV_W'(step);
        end
        quo = (64'(target) << 24) / (64'(env_q) + 64'd1);
        if (quo > 64'(GAIN_MAX)) quo = 64'(GAIN_MAX);
        if (quo < 64'(GAIN_MIN)) quo = 64'(GAIN_MIN);
        want = GAIN_W'(quo);
        if (want >= gain_q) begin
          step   = (64'(SMOOTH_K) * 64'(want - gain_q) + (64'd1 << 23)) >> 24;
          gain_q = gain_q + GAIN_W'(step);
        end else begin
          step   = (64'(SMOOTH_K) * 64'(gain_q - want) + (64'd1 << 23)) >> 24;
          gain_q = gain_q - GAIN_W'(step);
        end
        gain = gain_q;
      end else begin
        gain = GAIN_ONE;
      end
      prod = 64'(mag) * 64'(gain) * 64'(vol);
      r = (prod + (64'd1 << 27)) >> 28;
      if (s[SAMPLE_W-1]) begin
        if (r > 64'd32768) r = 64'd32768;
        leveled_due.push_back(SAMPLE_W'(64'd65536 - r));
      end else begin
        if (r > 64'd32767) r = 64'd32767;
        leveled_due.push_back(SAMPLE_W'(r));
      end
    endfunction

    function void check_leveled(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (leveled_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, got %0d", $time, got);
        return;
      end
      want = leveled_due.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: sample_out mismatch, expected %0d, got %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return leveled_due.size();
    endfunction
  endclass

  logic                         clk        = 1'b0;
  logic                         rst        = 1'b1;
  logic                         cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index  = '0;
  logic [CFG_DATA_W-1:0]        cfg_data   = '0;
  logic                         in_valid   = 1'b0;
  logic                         in_stall;
  logic signed [SAMPLE_W-1:0]   sample_in  = '0;
  logic                         out_valid;
  logic                         out_stall  = 1'b0;
  logic signed [SAMPLE_W-1:0]   sample_out;

  level_tracker lt;
  int src_idle_pct = 6;
  int dst_idle_pct = 59;
  int level        = 1024;
  int words_sent   = 0;
  int settings     = 0;

  audio_agc_leveler u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < dst_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) lt.check_leveled(sample_out);
  end

  task automatic send_word(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 170);
      repeat (gap) @(posedge clk);
    end
    sample_in <= s;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lt.take_sample(s);
    words_sent++;
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (lt.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    lt.set_reg(idx, data);
  endtask

  task automatic close_cfg();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 24'hFF_FFFF;
      2:       return 24'd34900;
      3:       return 24'd2330;
      4:       return COEF_W'($urandom_range(0, 1 << 16));
      default: return COEF_W'($urandom);
    endcase
  endfunction

  task automatic randomize_regs();
    logic [31:0] r;
    logic [TARGET_W-1:0] t;
    logic [VOL_W-1:0] v;
    r = $urandom;
    write_reg(REG_AGC_ENABLE, {r[23:1], 1'($urandom_range(0, 4) != 0)});
    case ($urandom_range(0, 3))
      0:       t = '0;
      1:       t = 15'h7FFF;
      2:       t = 15'd9830;
      default: t = TARGET_W'($urandom);
    endcase
    write_reg(REG_TARGET_LEVEL, {r[31:23], t});
    write_reg(REG_ATTACK_COEF, pick_coef());
    write_reg(REG_RELEASE_COEF, pick_coef());
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = 16'hFFFF;
      2:       v = 16'd1;
      3, 4:    v = 16'd4096;
      default: v = VOL_W'($urandom_range(1, 65535));
    endcase
    write_reg(REG_VOLUME, {r[15:8], v});
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(REG_VOLUME + $urandom_range(1, 3)), CFG_DATA_W'($urandom));
    close_cfg();
  endtask

  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    int v;
    if ($urandom_range(0, 39) == 0) begin
      case ($urandom_range(0, 4))
        0:       level = 0;
        1:       level = 64;
        2:       level = 2048;
        3:       level = 16384;
        default: level = 32768;
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
      3, 4:    v = int'($urandom_range(0, 511)) - 256;
      5:       v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = int'($urandom_range(0, 2 * level)) - level;
    endcase
    if (v > 32767) v = 32767;
    return SAMPLE_W'(v);
  endfunction

  initial begin
    lt = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults
    send_word(16'sd0);
    send_word(16'sd32767);
    send_word(-16'sd32768);
    send_word(16'sd1);
    send_word(-16'sd1);
    send_word(16'sd16384);
    send_word(-16'sd20000);
    finish_phase();

    // full volume, fastest envelope: drive output into saturation
    write_reg(REG_VOLUME, 24'h00_FFFF);
    write_reg(REG_TARGET_LEVEL, 24'h00_7FFF);
    write_reg(REG_ATTACK_COEF, 24'hFF_FFFF);
    write_reg(REG_RELEASE_COEF, 24'hFF_FFFF);
    close_cfg();
    send_word(16'sd32767);
    send_word(-16'sd32768);
    send_word(16'sd100);
    send_word(-16'sd100);
    send_word(16'sd0);
    finish_phase();

    // mute through truncated write data; unused indexes ignored
    write_reg(REG_VOLUME, 24'hFF_0000);
    write_reg(CFG_IDX_W'(REG_VOLUME + 1), 24'hFF_FFFF);
    write_reg(CFG_IDX_W'(REG_VOLUME + 2), 24'h00_0000);
    write_reg(CFG_IDX_W'(REG_VOLUME + 3), 24'hA5_5A5A);
    close_cfg();
    send_word(16'sd32767);
    send_word(-16'sd32768);
    send_word(16'sd5);
    finish_phase();

    // bypass: volume only
    write_reg(REG_VOLUME, 24'hAB_1000);
    write_reg(REG_AGC_ENABLE, 24'hFF_FFFE);
    write_reg(REG_TARGET_LEVEL, 24'h00_0000);
    close_cfg();
    send_word(-16'sd32768);
    send_word(16'sd32767);
    send_word(16'sd1234);
    finish_phase();
    write_reg(REG_VOLUME, 24'h00_FFFF);
    close_cfg();
    send_word(16'sd32767);
    send_word(-16'sd32768);
    finish_phase();

    // zero target and frozen envelope: gain target clamped to its floor
    write_reg(REG_AGC_ENABLE, 24'hFF_FFFF);
    write_reg(REG_ATTACK_COEF, 24'h00_0000);
    write_reg(REG_RELEASE_COEF, 24'h00_0000);
    close_cfg();
    send_word(16'sd32767);
    send_word(-16'sd32768);
    send_word(16'sd0);
    finish_phase();

    while (words_sent - 23 < RAND_WORDS) begin
      if (words_sent - 23 < RAND_WORDS / 3) begin
        src_idle_pct = 6;
        dst_idle_pct = 59;
      end else if (words_sent - 23 < 2 * RAND_WORDS / 3) begin
        src_idle_pct = 59;
        dst_idle_pct = 6;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      randomize_regs();
      repeat ($urandom_range(100, 300)) send_word(next_sample());
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lt.pending() != 0) begin
      lt.errors++;
      $display("%0t: %0d expected words never arrived", $time, lt.pending());
    end
    $display("Run: %0d samples sent over %0d register settings, %0d words checked,",
             words_sent, settings, lt.checked);
    $display("     %0d errors; mute, bypass, saturation and clamp cases included", lt.errors);
    if (lt.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("tb: failure");
    $finish;
  end

endmodule
